/* rtl/b64lw_pkg.sv */
// ----------------------------------------------------------------------------
// b64lw_pkg
// Shared types, constants and the base64 alphabet for the line-wrapped encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64lw_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CHAR_PAD  = 8'h3D;  // '='
  localparam logic [7:0] CHAR_NL   = 8'h0A;  // newline
  localparam logic [7:0] CHAR_PLUS = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLSH = 8'h2F;  // '/'

  localparam logic [5:0] GPL_RESET = 6'd16;

  // Index of the trailing newline within a job
  localparam logic [2:0] IDX_NL = 3'd4;

  // One job: a group of four sextets plus how to finish it
  typedef struct packed {
    logic [23:0] sext;     // four sextets, first in the top bits
    logic [1:0]  pads;     // number of '=' closing the group (0..2)
    logic        nl;       // a newline follows the group
    logic        nl_last;  // that newline closes the message
  } job_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Map a sextet onto the standard alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] ve;
    ve = {2'b00, v};
    if (v < 6'd26)      b64_char = 8'd65 + ve;   // 'A'..'Z'
    else if (v < 6'd52) b64_char = ve + 8'd71;   // 'a'..'z'
    else if (v < 6'd62) b64_char = ve - 8'd4;    // '0'..'9'
    else if (v == 6'd62) b64_char = CHAR_PLUS;
    else                b64_char = CHAR_SLSH;
  endfunction

endpackage

`default_nettype wire

/* rtl/b64lw_in_if.sv */
// ----------------------------------------------------------------------------
// b64lw_in_if
// Byte channel into the encoder: one message byte and its end flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64lw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* rtl/b64lw_out_if.sv */
// ----------------------------------------------------------------------------
// b64lw_out_if
// Character channel out of the encoder: one ASCII character per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64lw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

`default_nettype wire

/* rtl/b64lw_front.sv */
// ----------------------------------------------------------------------------
// b64lw_front
// Accepts bytes, gathers three-byte groups, tracks the line position and
// pushes one job per finished group or tail into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module b64lw_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [5:0]           cfg_wdata,
  b64lw_in_if.sink                  in_ch,
  input  wire b64lw_pkg::fifo_stat_t stat,
  output logic                      push,
  output b64lw_pkg::job_t           push_job
);
  import b64lw_pkg::*;

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [5:0]  gol_r, gol_nxt;
  logic [5:0]  gpl_r;
  logic        acc;
  logic [5:0]  gol_inc;
  logic [7:0]  b1, b2, by;

  assign in_ch.ready = !stat.full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign b1          = pend_r[15:8];
  assign b2          = pend_r[7:0];
  assign by          = in_ch.data_byte;
  assign gol_inc     = gol_r + 6'd1;

  // Hold the line length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpl_r <= GPL_RESET;
    end else if (cfg_we) begin
      gpl_r <= cfg_wdata;
    end
  end

  // Classify the byte by group phase and build the job
  always_comb begin
    pend_nxt          = pend_r;
    phase_nxt         = phase_r;
    gol_nxt           = gol_r;
    push              = 1'b0;
    push_job          = '0;
    if (acc) begin
      case (phase_r)
        2'd0: begin
          if (!in_ch.last_byte) begin
            pend_nxt  = {by, 8'h00};
            phase_nxt = 2'd1;
          end else begin
            push             = 1'b1;
            push_job.sext    = {by[7:2], by[1:0], 4'h0, 12'h000};
            push_job.pads    = 2'd2;
            push_job.nl      = 1'b1;
            push_job.nl_last = 1'b1;
            pend_nxt         = '0;
            phase_nxt        = 2'd0;
            gol_nxt          = '0;
          end
        end
        2'd1: begin
          if (!in_ch.last_byte) begin
            pend_nxt  = {b1, by};
            phase_nxt = 2'd2;
          end else begin
            push             = 1'b1;
            push_job.sext    = {b1[7:2], b1[1:0], by[7:4], by[3:0], 2'b00, 6'h00};
            push_job.pads    = 2'd1;
            push_job.nl      = 1'b1;
            push_job.nl_last = 1'b1;
            pend_nxt         = '0;
            phase_nxt        = 2'd0;
            gol_nxt          = '0;
          end
        end
        default: begin
          push          = 1'b1;
          push_job.sext = {b1[7:2], b1[1:0], b2[7:4], b2[3:0], by[7:6], by[5:0]};
          push_job.pads = 2'd0;
          pend_nxt      = '0;
          phase_nxt     = 2'd0;
          if (in_ch.last_byte) begin
            push_job.nl      = 1'b1;
            push_job.nl_last = 1'b1;
            gol_nxt          = '0;
          end else if (gol_inc == gpl_r) begin
            push_job.nl = 1'b1;
            gol_nxt     = '0;
          end else begin
            gol_nxt = gol_inc;
          end
        end
      endcase
    end
  end

  // Advance message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      gol_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      gol_r   <= gol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

endmodule

`default_nettype wire

/* rtl/b64lw_fifo.sv */
// ----------------------------------------------------------------------------
// b64lw_fifo
// Short job queue between the front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module b64lw_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire b64lw_pkg::job_t  push_job,
  input  wire logic             pop,
  output b64lw_pkg::job_t       pop_job,
  output b64lw_pkg::fifo_stat_t stat
);
  import b64lw_pkg::*;

  job_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     cnt_r;
  logic                 do_push, do_pop;

  assign stat.full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_job    = mem_r[rd_ptr_r];

  // Write the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/b64lw_back.sv */
// ----------------------------------------------------------------------------
// b64lw_back
// Takes jobs from the queue and emits their characters one per cycle, while the
// output is ready, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64lw_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire b64lw_pkg::job_t       pop_job,
  input  wire b64lw_pkg::fifo_stat_t stat,
  output logic                       pop,
  b64lw_out_if.source                out_ch
);
  import b64lw_pkg::*;

  job_t       job_r;
  logic       job_vld_r;
  logic [2:0] idx_r;
  logic       out_vld_r;
  logic [7:0] out_char_r;
  logic       out_last_r;
  logic       advance, done;
  logic [2:0] last_idx, n_sym;
  logic [5:0] sx;
  logic [7:0] ch;

  assign out_ch.valid     = out_vld_r;
  assign out_ch.out_char  = out_char_r;
  assign out_ch.last_char = out_last_r;

  assign advance  = job_vld_r && (!out_vld_r || out_ch.ready);
  assign last_idx = job_r.nl ? IDX_NL : 3'd3;
  assign done     = advance && (idx_r == last_idx);
  assign pop      = (!job_vld_r || done) && !stat.empty;
  assign n_sym    = 3'd4 - {1'b0, job_r.pads};

  // Pick the sextet for the current position
  always_comb begin
    case (idx_r[1:0])
      2'd0:    sx = job_r.sext[23:18];
      2'd1:    sx = job_r.sext[17:12];
      2'd2:    sx = job_r.sext[11:6];
      default: sx = job_r.sext[5:0];
    endcase
  end

  // Select alphabet, pad or newline
  always_comb begin
    if (idx_r == IDX_NL)    ch = CHAR_NL;
    else if (idx_r < n_sym) ch = b64_char(sx);
    else                    ch = CHAR_PAD;
  end

  // Load, step and retire jobs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      idx_r     <= '0;
    end else if (pop) begin
      job_vld_r <= 1'b1;
      idx_r     <= '0;
    end else if (done) begin
      job_vld_r <= 1'b0;
    end else if (advance) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= pop_job;
    end
  end

  // Hold the output beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char_r <= ch;
      out_last_r <= (idx_r == IDX_NL) && job_r.nl_last;
    end
  end

endmodule

`default_nettype wire

/* rtl/base64_line_wrapped_encoder_top.sv */
// Path: a byte that completes a group or ends the message goes through the queue,
//   the job register and the output register. A group is four characters (five
//   with a newline), given one per cycle while the output is ready; bytes are
//   taken one per cycle while the four-entry queue has room.
// Reset: synchronous, active low; clears the queue, group phase, line count and
//   output valid, and sets the line length to 16 groups.
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder_top
// Streaming base64 encoder with '=' padding and line wrapping.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_line_wrapped_encoder_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [5:0] cfg_wdata,
  b64lw_in_if.sink        in_ch,
  b64lw_out_if.source     out_ch
);
  import b64lw_pkg::*;

  logic       push, pop;
  job_t       push_job, pop_job;
  fifo_stat_t stat;

  b64lw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .stat     (stat),
    .push     (push),
    .push_job (push_job)
  );

  b64lw_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .pop_job (pop_job),
    .stat    (stat)
  );

  b64lw_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .pop_job(pop_job),
    .stat   (stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

/* rtl/b64lw_checker.sv */
// ----------------------------------------------------------------------------
// b64lw_checker
// Port-level checks on the encoder output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module b64lw_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic       last_char
);
  import b64lw_pkg::*;

  // Keep a stalled beat up
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // Keep a stalled character steady
  a_char_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_char) && $stable(last_char))
    else $error("output character changed while stalled");

  // Only the closing newline carries the end flag
  a_last_is_nl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_char |-> out_char == CHAR_NL)
    else $error("end flag on a character other than newline");

  // Reset leaves no output beat
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind base64_line_wrapped_encoder_top b64lw_checker u_b64lw_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_char (out_ch.out_char),
  .last_char(out_ch.last_char)
);

`default_nettype wire

/* tb/sv/base64_line_wrapped_encoder_top_test.sv */
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder_top_test
// Self-checking bench for the line-wrapped base64 encoder. Messages are fed
// byte by byte through the input channel. A local encoder model predicts
// every character, pad and newline, and the output channel is scoreboarded
// beat by beat. Both channels idle at random. The line length is changed
// between phases, and once in the middle of a line.
// ----------------------------------------------------------------------------

module base64_line_wrapped_encoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import b64lw_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } msg_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } enc_char_t;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TARGET_BYTES = 370;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned MAX_SHOWN    = 10;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [5:0] cfg_wdata;

  b64lw_in_if  in_ch ();
  b64lw_out_if out_ch ();

  base64_line_wrapped_encoder_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Encoder model state
  logic [5:0]  m_line_len;
  logic [15:0] m_held;
  logic [1:0]  m_phase;
  logic [5:0]  m_line_groups;

  msg_byte_t   tx_bytes[$];
  enc_char_t   expected_chars[$];

  int unsigned bytes_queued   = 0;
  int unsigned bytes_taken    = 0;
  int unsigned chars_checked  = 0;
  int unsigned msgs_closed    = 0;
  int unsigned line_breaks    = 0;
  int unsigned len_writes     = 0;
  int unsigned fails          = 0;
  int unsigned cycles         = 0;

  int   src_gap     = 0;
  int   snk_gap     = 0;
  bit   src_idle_on = 1'b1;
  bit   snk_idle_on = 1'b1;
  bit   snk_hold    = 1'b0;
  bit   hold_req    = 1'b0;
  logic in_taken    = 1'b0;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still awaited",
               cycles, expected_chars.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Map a sextet onto A-Z a-z 0-9 + /
  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    logic [7:0] v;
    v = {2'b00, s};
    if (v < 8'd26) return 8'h41 + v;
    if (v < 8'd52) return 8'h61 + (v - 8'd26);
    if (v < 8'd62) return 8'h30 + (v - 8'd52);
    if (v == 8'd62) return CHAR_PLUS;
    return CHAR_SLSH;
  endfunction

  function automatic void add_char(input logic [7:0] c, input logic f);
    enc_char_t e;
    e.ch  = c;
    e.fin = f;
    expected_chars.push_back(e);
  endfunction

  function automatic void close_message();
    add_char(CHAR_NL, 1'b1);
    m_held        = '0;
    m_phase       = '0;
    m_line_groups = '0;
    msgs_closed++;
  endfunction

  // Predict the characters caused by one accepted byte
  function automatic void encode_beat(input logic [7:0] b, input logic fin);
    logic [7:0] b1;
    logic [7:0] b2;
    b1 = m_held[15:8];
    b2 = m_held[7:0];
    case (m_phase)
      2'd0: begin
        if (!fin) begin
          m_held  = {b, 8'h00};
          m_phase = 2'd1;
        end else begin
          add_char(sextet_char(b[7:2]), 1'b0);
          add_char(sextet_char({b[1:0], 4'b0000}), 1'b0);
          add_char(CHAR_PAD, 1'b0);
          add_char(CHAR_PAD, 1'b0);
          close_message();
        end
      end
      2'd1: begin
        if (!fin) begin
          m_held[7:0] = b;
          m_phase     = 2'd2;
        end else begin
          add_char(sextet_char(b1[7:2]), 1'b0);
          add_char(sextet_char({b1[1:0], b[7:4]}), 1'b0);
          add_char(sextet_char({b[3:0], 2'b00}), 1'b0);
          add_char(CHAR_PAD, 1'b0);
          close_message();
        end
      end
      default: begin
        add_char(sextet_char(b1[7:2]), 1'b0);
        add_char(sextet_char({b1[1:0], b2[7:4]}), 1'b0);
        add_char(sextet_char({b2[3:0], b[7:6]}), 1'b0);
        add_char(sextet_char(b[5:0]), 1'b0);
        m_held        = '0;
        m_phase       = '0;
        m_line_groups = m_line_groups + 6'd1;
        if (fin) begin
          close_message();
        end else if (m_line_groups == m_line_len) begin
          add_char(CHAR_NL, 1'b0);
          m_line_groups = '0;
          line_breaks++;
        end
      end
    endcase
  endfunction

  // Idle length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // Byte driver: advance to the next queued byte once the current beat is taken
  always @(negedge clk) begin : drive_bytes
    msg_byte_t nb;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= '0;
      in_ch.last_byte <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (tx_bytes.size() != 0) begin
        nb = tx_bytes.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= nb.data;
        in_ch.last_byte <= nb.fin;
        src_gap = (src_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Character sink: random back-pressure plus the long hold
  always @(negedge clk) begin
    if (!rst_n || snk_hold) begin
      out_ch.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (snk_idle_on && $urandom_range(0, 3) == 0) snk_gap = idle_len();
    end
  end

  // Long receiver hold, counted here so the sender keeps offering bytes
  initial begin
    wait (hold_req);
    @(posedge clk);
    snk_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    snk_hold = 1'b0;
  end

  // Monitor: predict on input beats, check output beats
  always @(posedge clk) begin : watch_ports
    enc_char_t want;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        encode_beat(in_ch.data_byte, in_ch.last_byte);
        bytes_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          fails++;
          if (fails <= MAX_SHOWN)
            $display("unexpected char beat: got %h last=%b", out_ch.out_char,
                     out_ch.last_char);
        end else begin
          want = expected_chars.pop_front();
          if (want.ch !== out_ch.out_char || want.fin !== out_ch.last_char) begin
            fails++;
            if (fails <= MAX_SHOWN)
              $display("char beat %0d: expected char %h last %b, got char %h last %b",
                       chars_checked, want.ch, want.fin, out_ch.out_char,
                       out_ch.last_char);
          end
        end
      end
    end
  end

  task automatic queue_byte(input logic [7:0] d, input logic f);
    msg_byte_t mb;
    mb.data = d;
    mb.fin  = f;
    tx_bytes.push_back(mb);
    bytes_queued++;
  endtask

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_message(input int len, input bit closed);
    for (int i = 0; i < len; i++) queue_byte(rand_byte(), closed && (i == len - 1));
  endtask

  // Hold until everything queued has been taken and answered, then settle
  task automatic wait_idle();
    while (tx_bytes.size() != 0 || in_ch.valid || expected_chars.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Called at a falling edge while the block is idle
  task automatic write_line_len(input logic [5:0] v);
    cfg_we     <= 1'b1;
    cfg_wdata  <= v;
    m_line_len  = v;
    len_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 9);
    if (r < 90) return $urandom_range(10, 30);
    return $urandom_range(31, 60);
  endfunction

  initial begin : stimulus
    int step;
    int nmsg;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    m_line_len      = GPL_RESET;
    m_held          = '0;
    m_phase         = '0;
    m_line_groups   = '0;
    step            = 0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Tails of one and two bytes, all-ones and all-zeros, '+' and '/'
    @(posedge clk);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hF8, 1'b0);
    queue_byte(8'h0F, 1'b1);
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'hEF, 1'b0);
    queue_byte(8'hBE, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);

    // One group per line: a break after every group except the closing one
    wait_idle();
    write_line_len(6'd1);
    @(posedge clk);
    queue_byte(8'h4D, 1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h6E, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hFE, 1'b1);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h03, 1'b1);

    // Line length dropped to zero mid-line: the count wraps through 64
    wait_idle();
    write_line_len(6'd40);
    @(posedge clk);
    queue_message(3, 1'b0);
    wait_idle();
    write_line_len(6'd0);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b1;
    @(posedge clk);
    hold_req = 1'b1;
    queue_message(191, 1'b1);

    // Random messages under a sweep of line lengths
    while (bytes_queued < TARGET_BYTES) begin
      wait_idle();
      case (step % 4)
        0:       write_line_len(6'd63);
        1:       write_line_len(6'd2);
        2:       write_line_len(6'($urandom_range(1, 63)));
        default: write_line_len(6'($urandom_range(1, 4)));
      endcase
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      step++;
      nmsg = $urandom_range(2, 5);
      @(posedge clk);
      for (int i = 0; i < nmsg && bytes_queued < TARGET_BYTES; i++)
        queue_message(pick_len(), 1'b1);
    end

    wait_idle();
    $display("covered %0d bytes in %0d messages, %0d chars checked, %0d line breaks",
             bytes_taken, msgs_closed, chars_checked, line_breaks);
    $display("line length written %0d times, %0d mismatching beats", len_writes, fails);
    if (fails == 0 && expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
